>>> rtl/assert_macros.svh
// Assertion helpers used by the hash table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPHT_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LPHT_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/lpht_pkg.sv
package lpht_pkg;

   // Register and field widths fixed by the interface, and the reset table size.
   localparam int CSR_W      = 5;
   localparam int SIZE_RESET = 16;
   localparam int RAW_KEY_W  = 64;
   localparam int LEN_W      = 4;
   localparam int VALUE_W    = 32;

   // The byte sum of an eight byte key is at most 8 * 255, which needs 11 bits.
   localparam int SUM_W = 11;
   // The divisor is shifted up by SUM_W bits at the start of the remainder.
   localparam int DSH_W = SUM_W + CSR_W;
   // Two remainder bits are resolved per cycle, twelve shift positions in all.
   localparam int MOD_PAIRS = (SUM_W + 1) / 2;

   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_LOOKUP = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_REFUSED = 2'd1,
      STATUS_MISS    = 2'd2
   } status_type;

endpackage

>>> rtl/lpht_req_if.sv
interface lpht_req_if
   import lpht_pkg::*;
();
   logic                 valid;
   logic                 ready;
   kind_type             kind;
   logic [RAW_KEY_W-1:0] key_bytes;
   logic [LEN_W-1:0]     key_length;
   logic [VALUE_W-1:0]   value;

   modport source (output valid, kind, key_bytes, key_length, value, input ready);
   modport sink (input valid, kind, key_bytes, key_length, value, output ready);
endinterface

>>> rtl/lpht_rsp_if.sv
interface lpht_rsp_if
   import lpht_pkg::*;
();
   logic               valid;
   logic               ready;
   status_type         status;
   logic [VALUE_W-1:0] found_value;

   modport source (output valid, status, found_value, input ready);
   modport sink (input valid, status, found_value, output ready);
endinterface

>>> rtl/lpht_ram.sv
module lpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/linear_probe_hash_table.sv
// Key/value table with open addressing and linear probing.
// The req channel carries one transaction per operation: an insert of a key with a
// value, or a lookup of a key. Keys are up to eight bytes, cut at the given length
// and at the first zero byte. The rsp channel returns exactly one transaction per
// request, in order, with a status and, on a lookup hit, the stored value.
// The csr port writes the table size (slots in use, clamped to 1..SLOTS and to 31).
// Write it only while no request is in flight.
// Operation: the request is taken and its key normalized and summed into the request
// registers, then ST_MOD finds the remainder of the byte sum by the table size (two
// bits per cycle), then ST_PROBE reads one slot after another from the key/value
// memory, which answers one read per cycle. The result lands in the output register
// at the end of the last probe; the block works on one operation at a time, and the
// next request is accepted as soon as the block returns to idle.
// Reset clears all slot used bits at once and sets the table size to 16.
// When the receiver stalls, one finished transaction waits in the output register
// while the next request is taken and worked on; that request holds its last probe
// until the output register is free, and only then commits an insert.

`include "assert_macros.svh"

module linear_probe_hash_table
   import lpht_pkg::*;
#(
   parameter int SLOTS     = 16,
   parameter int KEY_BYTES = 8
) (
   input  logic             clock,
   input  logic             reset,
   lpht_req_if.sink         req_if,
   lpht_rsp_if.source       rsp_if,
   input  logic             csr_write_enable,
   input  logic [CSR_W-1:0] csr_write_data
);
   // The size register holds at most 31, so slots above that are never probed.
   localparam int MAX_USE = (SLOTS < 31) ? SLOTS : 31;
   localparam int IW      = (MAX_USE > 1) ? $clog2(MAX_USE) : 1;
   localparam int KEY_W   = 8 * KEY_BYTES;
   localparam int ENTRY_W = KEY_W + VALUE_W;
   localparam int PAIR_W  = $clog2(MAX_USE > 0 ? MOD_PAIRS : 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MOD,
      ST_PROBE
   } state_type;

   state_type            state_ff, state_in;
   logic [CSR_W-1:0]     csr_size_ff, csr_size_in;
   logic [CSR_W-1:0]     size_ff, size_in;
   kind_type             kind_ff, kind_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [VALUE_W-1:0]   value_ff, value_in;
   logic [SUM_W-1:0]     rem_ff, rem_in;
   logic [DSH_W-1:0]     dsh_ff, dsh_in;
   logic [PAIR_W-1:0]    pair_ff, pair_in;
   logic [IW-1:0]        probe_ff, probe_in;
   logic [CSR_W-1:0]     cnt_ff, cnt_in;
   logic [MAX_USE-1:0]   used_ff, used_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]   rsp_value_ff, rsp_value_in;

   logic                 ram_we;
   logic [ENTRY_W-1:0]   ram_rd_data;

   // Key normalization and the byte sum for the request at the port.
   logic [RAW_KEY_W-1:0] norm_key;
   logic [SUM_W-1:0]     key_sum;
   logic [CSR_W-1:0]     eff_size;

   always_comb begin
      logic [LEN_W-1:0] n;
      logic             alive;
      logic [7:0]       b;
      norm_key = '0;
      key_sum  = '0;
      alive    = 1'b1;
      n = (req_if.key_length > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : req_if.key_length;
      for (int i = 0; i < 8; i++) begin
         b     = req_if.key_bytes[8*i +: 8];
         alive = alive && (LEN_W'(i) < n) && (b != 8'd0);
         if (alive) begin
            norm_key[8*i +: 8] = b;
            key_sum            = key_sum + SUM_W'(b);
         end
      end
   end

   // A size of zero acts as one; anything above the table depth acts as the depth.
   always_comb begin
      if (csr_size_ff == '0) begin
         eff_size = CSR_W'(1);
      end else if (csr_size_ff > CSR_W'(MAX_USE)) begin
         eff_size = CSR_W'(MAX_USE);
      end else begin
         eff_size = csr_size_ff;
      end
   end

   // Two restoring remainder steps per cycle.
   logic [SUM_W-1:0] rem_a, rem_b;
   logic [DSH_W-1:0] dsh_half;

   always_comb begin
      dsh_half = dsh_ff >> 1;
      rem_a    = rem_ff;
      if (DSH_W'(rem_ff) >= dsh_ff) begin
         rem_a = rem_ff - SUM_W'(dsh_ff);
      end
      rem_b = rem_a;
      if (DSH_W'(rem_a) >= dsh_half) begin
         rem_b = rem_a - SUM_W'(dsh_half);
      end
   end

   // Probe evaluation against the entry read for probe_ff.
   logic [KEY_W-1:0]   slot_key;
   logic [VALUE_W-1:0] slot_value;
   logic               slot_used;
   logic               key_hit;
   logic               stop_here;
   logic               exhausted;
   logic               out_free;
   logic [IW-1:0]      probe_next;

   assign slot_key   = ram_rd_data[ENTRY_W-1:VALUE_W];
   assign slot_value = ram_rd_data[VALUE_W-1:0];
   assign slot_used  = used_ff[probe_ff];
   assign key_hit    = slot_used && (slot_key == key_ff);
   assign stop_here  = !slot_used || key_hit;
   assign exhausted  = (cnt_ff == size_ff - CSR_W'(1));
   assign out_free   = !rsp_valid_ff || rsp_if.ready;
   assign probe_next = (CSR_W'(probe_ff) == size_ff - CSR_W'(1)) ? '0 : probe_ff + IW'(1);

   always_comb begin
      state_in      = state_ff;
      csr_size_in   = csr_write_enable ? csr_write_data : csr_size_ff;
      size_in       = size_ff;
      kind_in       = kind_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      rem_in        = rem_ff;
      dsh_in        = dsh_ff;
      pair_in       = pair_ff;
      probe_in      = probe_ff;
      cnt_in        = cnt_ff;
      used_in       = used_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      ram_we        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               kind_in  = req_if.kind;
               key_in   = norm_key[KEY_W-1:0];
               value_in = req_if.value;
               size_in  = eff_size;
               rem_in   = key_sum;
               dsh_in   = {eff_size, {SUM_W{1'b0}}};
               pair_in  = '0;
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            rem_in  = rem_b;
            dsh_in  = dsh_ff >> 2;
            pair_in = pair_ff + PAIR_W'(1);
            if (pair_ff == PAIR_W'(MOD_PAIRS - 1)) begin
               // The remainder is the home slot; its read is issued at this edge.
               probe_in = IW'(rem_b);
               cnt_in   = '0;
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (stop_here || exhausted) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = '0;
                  if (kind_ff == KIND_INSERT) begin
                     if (stop_here && !slot_used) begin
                        used_in[probe_ff] = 1'b1;
                        ram_we            = 1'b1;
                        rsp_status_in     = STATUS_OK;
                     end else begin
                        rsp_status_in = STATUS_REFUSED;
                     end
                  end else begin
                     if (key_hit) begin
                        rsp_status_in = STATUS_OK;
                        rsp_value_in  = slot_value;
                     end else begin
                        rsp_status_in = STATUS_MISS;
                     end
                  end
                  state_in = ST_IDLE;
               end
            end else begin
               probe_in = probe_next;
               cnt_in   = cnt_ff + CSR_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         csr_size_ff  <= CSR_W'(SIZE_RESET);
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         csr_size_ff  <= csr_size_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      size_ff       <= size_in;
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      rem_ff        <= rem_in;
      dsh_ff        <= dsh_in;
      pair_ff       <= pair_in;
      probe_ff      <= probe_in;
      cnt_ff        <= cnt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   // Keys and values live in one memory; the read address follows the next probe
   // slot so the entry for probe_ff is on the read port in every probe cycle.
   lpht_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_USE)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (probe_ff),
      .wr_data ({key_ff, value_ff}),
      .rd_addr (probe_in),
      .rd_data (ram_rd_data)
   );

   assign req_if.ready       = (state_ff == ST_IDLE);
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.found_value = rsp_value_ff;

   `LPHT_ASSERT_NEXT(a_home_in_range, clock, reset,
      state_ff == ST_MOD && pair_ff == PAIR_W'(MOD_PAIRS - 1),
      CSR_W'(probe_ff) < size_ff, "home slot is not below the table size")
   `LPHT_ASSERT_IMP(a_probe_in_range, clock, reset, state_ff == ST_PROBE,
      CSR_W'(probe_ff) < size_ff, "probe slot outside the table")
   `LPHT_ASSERT_IMP(a_probe_count, clock, reset, state_ff == ST_PROBE,
      cnt_ff < size_ff, "probe ran past the table size")
   `LPHT_ASSERT_IMP(a_no_overwrite, clock, reset, ram_we,
      !used_ff[probe_ff] && rsp_valid_in, "insert wrote a used slot or lost its response")
endmodule

>>> tb/linear_probe_hash_table_tb.sv
`timescale 1ns / 100ps

module linear_probe_hash_table_tb
   import lpht_pkg::*;
();

   // Table geometry of the instance under test (the block's default parameters).
   localparam int TABLE_SLOTS  = 16;
   localparam int KEY_LANES    = 8;
   localparam int POOL_DEPTH   = 24;
   localparam int PHASES       = 20;
   localparam int PHASE_ITEMS  = 82;
   localparam int GAP_MAX      = 8;
   // The receiver holds off this long a few times, so that the block fills up.
   localparam int LONG_HOLD    = 200;
   // Idle time at the end of the run: the worst case of one operation, and a little more.
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 400000;

   typedef struct packed {
      kind_type               kind;
      logic [RAW_KEY_W-1:0]   key_bytes;
      logic [LEN_W-1:0]       key_length;
      logic [VALUE_W-1:0]     value;
   } table_op_type;

   typedef struct packed {
      status_type             status;
      logic [VALUE_W-1:0]     found_value;
   } table_reply_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_write_enable;
   logic [CSR_W-1:0]    csr_write_data;

   lpht_req_if req_bus ();
   lpht_rsp_if rsp_bus ();

   linear_probe_hash_table dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_bus),
      .rsp_if           (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #4 clock = ~clock;

   // Operations waiting to be offered, and the replies the table must give, oldest first.
   table_op_type    pending_ops[$];
   table_reply_type expected_replies[$];

   // Our own copy of the table contents and of the size register.
   logic                 mirror_used  [TABLE_SLOTS];
   logic [RAW_KEY_W-1:0] mirror_key   [TABLE_SLOTS];
   logic [VALUE_W-1:0]   mirror_value [TABLE_SLOTS];
   logic [CSR_W-1:0]     mirror_size;

   // Canonical keys that the random part draws from, so that hits and duplicates are common.
   logic [RAW_KEY_W-1:0] key_pool [POOL_DEPTH];

   // Idle limits for each side; the stimulus process changes them per phase.
   int req_gap_max = GAP_MAX;
   int rsp_gap_max = GAP_MAX;

   int error_count    = 0;
   int results_seen   = 0;
   int stored_count   = 0;
   int refused_count  = 0;
   int hit_count      = 0;
   int miss_count     = 0;
   int sizes_written  = 0;
   int cycle_count    = 0;

   // Work out the reply to one operation and update our copy of the table.
   // The key is cut at its length (at most eight bytes) and at the first zero byte; the
   // home slot is the unsigned byte sum modulo the active size, and the probe walks up
   // from there until it meets a free slot or the same key, giving up after a full lap.
   function automatic table_reply_type predict_table_reply(table_op_type op);
      table_reply_type      reply;
      logic [RAW_KEY_W-1:0] k;
      int unsigned          active, span, sum, home, stop_slot, probe_slot;
      bit                   settled;
      active = (mirror_size == 0) ? 1 : (mirror_size > TABLE_SLOTS) ? TABLE_SLOTS : mirror_size;
      span = (op.key_length > KEY_LANES) ? KEY_LANES : op.key_length;
      k = '0;
      settled = 1'b0;
      for (int i = 0; i < KEY_LANES; i++) begin
         if (i < span && !settled) begin
            if (op.key_bytes[8*i +: 8] == 8'h00) settled = 1'b1;
            else k[8*i +: 8] = op.key_bytes[8*i +: 8];
         end
      end
      sum = 0;
      for (int i = 0; i < KEY_LANES; i++) sum += k[8*i +: 8];
      home = sum % active;
      // An exhausted probe ends back on the home slot.
      stop_slot = home;
      settled = 1'b0;
      for (int i = 0; i < active; i++) begin
         probe_slot = (home + i) % active;
         if (!settled && (!mirror_used[probe_slot] || mirror_key[probe_slot] == k)) begin
            stop_slot = probe_slot;
            settled = 1'b1;
         end
      end
      reply.found_value = '0;
      if (op.kind == KIND_INSERT) begin
         if (mirror_used[stop_slot]) begin
            reply.status = STATUS_REFUSED;
            refused_count++;
         end else begin
            mirror_used[stop_slot]  = 1'b1;
            mirror_key[stop_slot]   = k;
            mirror_value[stop_slot] = op.value;
            reply.status = STATUS_OK;
            stored_count++;
         end
      end else if (mirror_used[stop_slot] && mirror_key[stop_slot] == k) begin
         reply.status = STATUS_OK;
         reply.found_value = mirror_value[stop_slot];
         hit_count++;
      end else begin
         reply.status = STATUS_MISS;
         miss_count++;
      end
      return reply;
   endfunction

   // Build an operation for a canonical key, choosing at random one of the many raw
   // encodings that normalize to it: noise past the length, or a zero terminator
   // followed by noise under a longer length (up to the full four-bit range).
   function automatic table_op_type encode_op(kind_type kind, logic [RAW_KEY_W-1:0] k,
                                              logic [VALUE_W-1:0] value);
      table_op_type op;
      int           span;
      span = KEY_LANES;
      for (int i = KEY_LANES - 1; i >= 0; i--) if (k[8*i +: 8] == 8'h00) span = i;
      op.kind = kind;
      op.value = value;
      op.key_bytes = {$urandom, $urandom};
      for (int i = 0; i < KEY_LANES; i++) if (i < span) op.key_bytes[8*i +: 8] = k[8*i +: 8];
      if (span == KEY_LANES) begin
         op.key_length = LEN_W'($urandom_range(KEY_LANES, 15));
      end else if ($urandom_range(0, 1) == 0) begin
         op.key_length = LEN_W'(span);
      end else begin
         op.key_bytes[8*span +: 8] = 8'h00;
         op.key_length = LEN_W'($urandom_range(span + 1, 15));
      end
      return op;
   endfunction

   // Request driver. It also watches the csr port so that the size copy follows each write,
   // and predicts the reply of every accepted transaction at the edge that accepts it.
   table_op_type offered_op;
   bit           req_taken;
   int           send_wait;
   int           send_draw;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_wait <= 0;
         mirror_size = CSR_W'(SIZE_RESET);
         for (int i = 0; i < TABLE_SLOTS; i++) mirror_used[i] = 1'b0;
      end else begin
         if (csr_write_enable) mirror_size = csr_write_data;
         req_taken = req_bus.valid && req_bus.ready;
         send_draw = 0;
         if (req_taken) begin
            expected_replies.push_back(predict_table_reply(offered_op));
            send_draw = $urandom_range(0, req_gap_max);
         end
         if (req_bus.valid && !req_taken) begin
            // Keep offering the same transaction until it is taken.
         end else if (req_taken && send_draw > 0) begin
            req_bus.valid <= 1'b0;
            send_wait <= send_draw - 1;
         end else if (!req_taken && send_wait > 0) begin
            send_wait <= send_wait - 1;
         end else if (pending_ops.size() > 0) begin
            offered_op = pending_ops.pop_front();
            req_bus.kind       <= offered_op.kind;
            req_bus.key_bytes  <= offered_op.key_bytes;
            req_bus.key_length <= offered_op.key_length;
            req_bus.value      <= offered_op.value;
            req_bus.valid      <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Reply monitor and receiver. Every accepted reply is compared with the oldest
   // prediction. A few times in the run the receiver holds off for a long stretch while
   // the driver keeps offering, so the output register and the request stage both fill.
   table_reply_type wanted;
   int              hold_left;
   int              hold_draw;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= 0;
      end else if (rsp_bus.valid && rsp_bus.ready) begin
         if (expected_replies.size() == 0) begin
            $error("reply transaction with nothing expected: status %0d, found_value %0h",
                   rsp_bus.status, rsp_bus.found_value);
            error_count++;
         end else begin
            wanted = expected_replies.pop_front();
            if (rsp_bus.status !== wanted.status) begin
               $error("status mismatch: expected %0d, actual %0d",
                      wanted.status, rsp_bus.status);
               error_count++;
            end
            if (rsp_bus.found_value !== wanted.found_value) begin
               $error("found_value mismatch: expected %0h, actual %0h",
                      wanted.found_value, rsp_bus.found_value);
               error_count++;
            end
         end
         results_seen++;
         hold_draw = (results_seen % 500 == 300) ? LONG_HOLD : $urandom_range(0, rsp_gap_max);
         if (hold_draw > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left <= hold_draw - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end else if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $error("run did not finish within %0d cycles", CYCLE_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Wait until every queued transaction has been taken and every reply has come back.
   task automatic drain();
      do @(negedge clock);
      while (pending_ops.size() != 0 || req_bus.valid || expected_replies.size() != 0);
   endtask

   // The size register may only change while the table is idle.
   task automatic write_table_size(input logic [CSR_W-1:0] size_value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= size_value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sizes_written++;
      @(negedge clock);
   endtask

   task automatic queue_op(input kind_type kind, input logic [RAW_KEY_W-1:0] raw,
                           input logic [LEN_W-1:0] len, input logic [VALUE_W-1:0] value);
      pending_ops.push_back('{kind: kind, key_bytes: raw, key_length: len, value: value});
   endtask

   // Table sizes for the random phases. They start small so that the table fills up
   // gradually, and include the out-of-range settings 0 (acts as 1) and above 16.
   function automatic logic [CSR_W-1:0] phase_size(int phase);
      case (phase)
         0:       return 5'd1;
         1:       return 5'd2;
         2:       return 5'd3;
         3:       return 5'd5;
         4:       return 5'd7;
         5:       return 5'd0;
         6:       return 5'd9;
         7:       return 5'd16;
         8:       return 5'd12;
         9:       return 5'd31;
         10:      return 5'd4;
         11:      return 5'd16;
         12:      return 5'd6;
         13:      return 5'd13;
         14:      return 5'd20;
         15:      return 5'd16;
         16:      return 5'd10;
         17:      return 5'd15;
         18:      return 5'd8;
         default: return 5'd16;
      endcase
   endfunction

   initial begin
      int                   span;
      logic [RAW_KEY_W-1:0] pool_key;
      table_op_type         op;

      // Every input known from time zero, with reset asserted.
      reset              = 1'b1;
      csr_write_enable   = 1'b0;
      csr_write_data     = '0;
      req_bus.valid      = 1'b0;
      req_bus.kind       = KIND_INSERT;
      req_bus.key_bytes  = '0;
      req_bus.key_length = '0;
      req_bus.value      = '0;
      rsp_bus.ready      = 1'b0;

      // A few hand-picked keys: the empty key, all ones, two keys with the same byte
      // sum, bytes with the top bit set, and a single small byte. The rest are random.
      key_pool[0] = '0;
      key_pool[1] = '1;
      key_pool[2] = 64'h6261;
      key_pool[3] = 64'h6162;
      key_pool[4] = 64'h9080;
      key_pool[5] = 64'h01;
      for (int i = 6; i < POOL_DEPTH; i++) begin
         span = $urandom_range(1, KEY_LANES);
         pool_key = '0;
         for (int b = 0; b < KEY_LANES; b++)
            if (b < span) pool_key[8*b +: 8] = 8'($urandom_range(1, 255));
         key_pool[i] = pool_key;
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part at the reset size of 16. Lookup on an empty table misses.
      queue_op(KIND_LOOKUP, 64'h41, 4'd1, 32'h0);
      // Length zero gives the empty key even though every raw bit is set.
      queue_op(KIND_INSERT, '1, 4'd0, 32'hFFFF_FFFF);
      // A zero first byte also gives the empty key, whatever follows it.
      queue_op(KIND_LOOKUP, 64'h1234_5678_9ABC_DE00, 4'd3, 32'h0);
      // All-ones key; lengths past eight act as eight.
      queue_op(KIND_INSERT, '1, 4'd15, 32'h0);
      queue_op(KIND_LOOKUP, '1, 4'd8, 32'h0);
      queue_op(KIND_INSERT, '1, 4'd9, 32'h5);
      // Two keys with equal byte sums collide; the second one probes onward.
      queue_op(KIND_INSERT, 64'hDEAD_BEEF_CAFE_6261, 4'd2, 32'h1111_1111);
      queue_op(KIND_INSERT, 64'h6162, 4'd8, 32'h2222_2222);
      queue_op(KIND_LOOKUP, 64'h7777_7777_7700_6162, 4'd5, 32'h0);
      queue_op(KIND_LOOKUP, 64'h6261, 4'd2, 32'h0);
      // High bytes must be summed unsigned; the home slot is taken, so it moves on.
      queue_op(KIND_INSERT, 64'h9080, 4'd4, 32'h8000_0001);
      queue_op(KIND_LOOKUP, 64'hFFFF_FFFF_FF00_9080, 4'd15, 32'h0);
      // A longer key with the same prefix is a different key.
      queue_op(KIND_LOOKUP, 64'h63_6261, 4'd3, 32'h0);
      queue_op(KIND_LOOKUP, 64'h63, 4'd1, 32'h0);
      drain();

      // Size 0 acts as one slot, already holding the empty key: the probe is exhausted.
      write_table_size(5'd0);
      queue_op(KIND_INSERT, 64'h63, 4'd1, 32'h3333_3333);
      queue_op(KIND_LOOKUP, 64'h6261, 4'd2, 32'h0);
      queue_op(KIND_LOOKUP, 64'h0, 4'd0, 32'h0);
      drain();

      // Sizes above 16 act as 16.
      write_table_size(5'd31);
      queue_op(KIND_LOOKUP, 64'h6162, 4'd2, 32'h0);
      queue_op(KIND_INSERT, 64'h0102_0304_0506_0708, 4'd8, 32'h0F0F_0F0F);
      drain();

      // Shrinking the table hides the entries stored beyond the new size.
      write_table_size(5'd4);
      queue_op(KIND_LOOKUP, '1, 4'd8, 32'h0);
      queue_op(KIND_INSERT, '1, 4'd8, 32'hA5A5_5A5A);
      queue_op(KIND_LOOKUP, 64'h9080, 4'd2, 32'h0);
      drain();

      // Random phases, one table size each. Most operations reuse the key pool under
      // fresh encodings, so hits, refusals and collisions are frequent; the rest are raw
      // noise. Idling changes from phase to phase, with some phases running back to back.
      for (int phase = 0; phase < PHASES; phase++) begin
         write_table_size(phase_size(phase));
         req_gap_max = (phase % 3 == 0) ? 0 : GAP_MAX;
         rsp_gap_max = (phase % 4 == 1) ? 0 : GAP_MAX;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 4) == 0) begin
               op.kind       = kind_type'($urandom_range(0, 1));
               op.key_bytes  = {$urandom, $urandom};
               op.key_length = LEN_W'($urandom_range(0, 15));
               op.value      = $urandom;
            end else begin
               op = encode_op(kind_type'($urandom_range(0, 1)),
                              key_pool[$urandom_range(0, POOL_DEPTH - 1)], $urandom);
            end
            pending_ops.push_back(op);
         end
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d transactions over %0d size settings: %0d stored, %0d refused,",
               results_seen, sizes_written, stored_count, refused_count);
      $display("%0d lookup hits and %0d lookup misses, with long receiver hold-offs.",
               hit_count, miss_count);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
